// ----- rtl/dhb_pkg.sv -----
`default_nettype none
package dhb_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int DEPTH_DEF    = 64;

  localparam int SAMPLE_W = 16;
  localparam int FILL_W   = 7;
  localparam int CHNUM_W  = 3;
  localparam int RDPOS_W  = 6;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [FILL_W-1:0]          fill_t;
  typedef logic [CHNUM_W-1:0]         chnum_t;
  typedef logic [RDPOS_W-1:0]         rdpos_t;

endpackage
`default_nettype wire

// ----- rtl/dhb_in_if.sv -----
`default_nettype none
interface dhb_in_if
  import dhb_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    func;
  chnum_t  channel_number;
  sample_t sample_value;
  rdpos_t  read_position;

  modport source (
    output valid, func, channel_number, sample_value, read_position,
    input  ready
  );

  modport sink (
    input  valid, func, channel_number, sample_value, read_position,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/dhb_out_if.sv -----
`default_nettype none
interface dhb_out_if
  import dhb_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    accepted;
  logic    compacted;
  fill_t   fill_count;
  sample_t read_value;

  modport source (
    output valid, accepted, compacted, fill_count, read_value,
    input  ready
  );

  modport sink (
    input  valid, accepted, compacted, fill_count, read_value,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/dhb_ram.sv -----
`default_nettype none
module dhb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/decimating_history_buffer.sv -----
`default_nettype none
// Channel   Dir  Beat fields
// item      in   func, channel_number, sample_value, read_position
// result    out  accepted, compacted, fill_count, read_value
//
// One item at a time. Push: EXEC then FIN from accept to result; a push into a
// full history runs the decimation walk (DEC, then APP) between them, bound by
// the single RAM read and write port. Read: EXEC, RD when the RAM is read, FIN.
// Reset clears fill counts only; entries at or past a fill count read as zero,
// so the sample RAM needs no clearing pass. A stalled result sits in the
// output register while the next item is taken and processed.
module decimating_history_buffer
  import dhb_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int DEPTH    = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dhb_in_if.sink     item,
  dhb_out_if.source  result
);

  localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW   = $clog2(DEPTH);
  localparam int AW   = CHW + PW;
  localparam int HALF = DEPTH / 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_APP  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]    state;
  logic [PW-1:0] k;
  fill_t         fill [2**CHW];
  logic          out_valid;

  logic          op_func;
  chnum_t        op_chnum;
  sample_t       op_sample;
  rdpos_t        op_pos;

  logic          res_accepted;
  logic          res_compacted;
  fill_t         res_fill;
  sample_t       res_value;

  logic          out_accepted;
  logic          out_compacted;
  fill_t         out_fill;
  sample_t       out_value;

  logic            chan_ok;
  logic [CHW-1:0]  ch;
  fill_t           cur_fill;
  logic            pos_ok;
  logic            full;
  logic            slot_free;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  assign chan_ok   = (op_chnum != '0) && (op_chnum <= CHNUM_W'(CHANNELS));
  assign ch        = CHW'(op_chnum - chnum_t'(1));
  assign cur_fill  = fill[ch];
  assign pos_ok    = (FILL_W'(op_pos) < FILL_W'(DEPTH)) && (FILL_W'(op_pos) < cur_fill);
  assign full      = cur_fill >= FILL_W'(DEPTH);
  assign slot_free = !out_valid || result.ready;

  assign item.ready        = (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.accepted   = out_accepted;
  assign result.compacted  = out_compacted;
  assign result.fill_count = out_fill;
  assign result.read_value = out_value;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {ch, cur_fill[PW-1:0]};
    ram_wdata = op_sample;
    ram_raddr = {ch, op_pos[PW-1:0]};
    case (state)
      S_EXEC: begin
        if (chan_ok && op_func == FUNC_PUSH && !full) begin
          ram_we = 1'b1;
        end
      end
      S_DEC: begin
        ram_raddr = {ch, PW'(k << 1)};
        if (k != '0) begin
          ram_we    = 1'b1;
          ram_waddr = {ch, PW'(k - PW'(1))};
          ram_wdata = ram_rdata;
        end
      end
      S_APP: begin
        ram_we    = 1'b1;
        ram_waddr = {ch, PW'(HALF)};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  dhb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (2**AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
      for (int i = 0; i < 2**CHW; i++) begin
        fill[i] <= '0;
      end
    end else begin
      if (state == S_FIN && slot_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!chan_ok) begin
            state <= S_FIN;
          end else if (op_func == FUNC_READ) begin
            state <= pos_ok ? S_RD : S_FIN;
          end else if (full) begin
            k     <= '0;
            state <= S_DEC;
          end else begin
            fill[ch] <= cur_fill + fill_t'(1);
            state    <= S_FIN;
          end
        end
        S_DEC: begin
          k <= k + PW'(1);
          if (k == PW'(HALF)) begin
            state <= S_APP;
          end
        end
        S_APP: begin
          fill[ch] <= FILL_W'(HALF + 1);
          state    <= S_FIN;
        end
        S_RD: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item.valid) begin
      op_func   <= item.func;
      op_chnum  <= item.channel_number;
      op_sample <= item.sample_value;
      op_pos    <= item.read_position;
    end
    case (state)
      S_EXEC: begin
        res_accepted  <= chan_ok;
        res_compacted <= 1'b0;
        res_value     <= '0;
        if (!chan_ok) begin
          res_fill <= '0;
        end else if (op_func == FUNC_PUSH && !full) begin
          res_fill <= cur_fill + fill_t'(1);
        end else begin
          res_fill <= cur_fill;
        end
      end
      S_APP: begin
        res_compacted <= 1'b1;
        res_fill      <= FILL_W'(HALF + 1);
      end
      S_RD: begin
        res_value <= sample_t'(ram_rdata);
      end
      S_FIN: begin
        if (slot_free) begin
          out_accepted  <= res_accepted;
          out_compacted <= res_compacted;
          out_fill      <= res_fill;
          out_value     <= res_value;
        end
      end
      default: begin
        res_accepted <= res_accepted;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sim/dhb_checker.sv -----
`timescale 1ns / 1ps
module dhb_checker
  import dhb_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int DEPTH    = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  dhb_in_if    item_mon,
  dhb_out_if   result_mon,
  output int   mismatches,
  output int   pending
);

  typedef struct packed {
    logic    accepted;
    logic    compacted;
    fill_t   fill_count;
    sample_t read_value;
  } status_t;

  sample_t   history [CHANNELS][DEPTH];
  fill_t     fill_level [CHANNELS];
  status_t   expected_q [$];
  int        errs = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Updates the shadow history and returns the status beat the item should produce.
  function automatic status_t apply_item(logic f, chnum_t c, sample_t s, rdpos_t p);
    status_t r;
    int      ch;
    int      lvl;
    r = '0;
    if (c >= 1 && c <= CHANNELS) begin
      ch = c - 1;
      r.accepted = 1'b1;
      if (f == FUNC_PUSH) begin
        lvl = fill_level[ch];
        if (lvl >= DEPTH) begin
          for (int i = 0; i < DEPTH / 2; i++) history[ch][i] = history[ch][2 * i];
          for (int i = DEPTH / 2; i < DEPTH; i++) history[ch][i] = '0;
          lvl = DEPTH / 2;
          r.compacted = 1'b1;
        end
        history[ch][lvl] = s;
        fill_level[ch]   = fill_t'(lvl + 1);
        r.fill_count     = fill_t'(lvl + 1);
      end else begin
        r.fill_count = fill_level[ch];
        if (p < DEPTH) r.read_value = history[ch][p];
      end
    end
    return r;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        fill_level[ch] = '0;
        for (int i = 0; i < DEPTH; i++) history[ch][i] = '0;
      end
      expected_q.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no item outstanding");
          errs++;
        end else begin
          want = expected_q.pop_front();
          compare_field("accepted", want.accepted, result_mon.accepted);
          compare_field("compacted", want.compacted, result_mon.compacted);
          compare_field("fill_count", want.fill_count, result_mon.fill_count);
          compare_field("read_value", want.read_value, result_mon.read_value);
        end
      end
      if (item_mon.valid && item_mon.ready)
        expected_q = {expected_q, apply_item(item_mon.func, item_mon.channel_number,
                                             item_mon.sample_value,
                                             item_mon.read_position)};
    end
    mismatches <= errs;
    pending    <= expected_q.size();
  end

endmodule

// ----- sim/tb_decimating_history_buffer.sv -----
`timescale 1ns / 1ps
module tb_decimating_history_buffer;
  import dhb_pkg::*;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int LONG_STALL     = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = DEPTH_DEF / 2 + 8;

  logic clk = 1'b0;
  logic rst;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dhb_in_if  item_ch ();
  dhb_out_if result_ch ();

  int mismatches;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit long_stall_req = 1'b0;
  bit long_stall_done = 1'b0;
  int quiet_cycles = 0;

  decimating_history_buffer #(
    .CHANNELS(CHANNELS_DEF),
    .DEPTH   (DEPTH_DEF)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  dhb_checker #(
    .CHANNELS(CHANNELS_DEF),
    .DEPTH   (DEPTH_DEF)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .item_mon  (item_ch),
    .result_mon(result_ch),
    .mismatches(mismatches),
    .pending   (pending)
  );

  task automatic send(logic f, chnum_t c, sample_t s, rdpos_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.func           <= f;
    item_ch.channel_number <= c;
    item_ch.sample_value   <= s;
    item_ch.read_position  <= p;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req && !long_stall_done) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        long_stall_done = 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int      done_items;
    int      phase;
    bit      drained_once;
    logic    f;
    chnum_t  c;
    sample_t s;

    rst                    <= 1'b1;
    item_ch.valid          <= 1'b0;
    item_ch.func           <= FUNC_PUSH;
    item_ch.channel_number <= '0;
    item_ch.sample_value   <= '0;
    item_ch.read_position  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty reads, ignored channels, extreme samples, reads past fill
    send(FUNC_READ, 3'd1, 16'sh0000, 6'd0);
    send(FUNC_READ, 3'd1, 16'sh0000, 6'd63);
    send(FUNC_PUSH, 3'd0, 16'sh7fff, 6'd0);
    send(FUNC_READ, 3'd0, 16'sh0000, 6'd0);
    send(FUNC_PUSH, 3'd5, 16'sh1234, 6'd0);
    send(FUNC_PUSH, 3'd7, 16'sh8000, 6'd63);
    send(FUNC_READ, 3'd6, 16'shffff, 6'd1);
    send(FUNC_PUSH, 3'd1, 16'sh8000, 6'd0);
    send(FUNC_PUSH, 3'd1, 16'sh7fff, 6'd63);
    send(FUNC_PUSH, 3'd1, 16'sh0000, 6'd0);
    send(FUNC_PUSH, 3'd1, 16'shffff, 6'd0);
    send(FUNC_READ, 3'd1, 16'sh0000, 6'd0);
    send(FUNC_READ, 3'd1, 16'sh0000, 6'd1);
    send(FUNC_READ, 3'd1, 16'sh0000, 6'd2);
    send(FUNC_READ, 3'd1, 16'sh0000, 6'd3);
    send(FUNC_READ, 3'd1, 16'sh0000, 6'd4);
    send(FUNC_READ, 3'd1, 16'sh0000, 6'd63);
    send(FUNC_PUSH, 3'd4, 16'sh7fff, 6'd0);
    send(FUNC_PUSH, 3'd4, 16'sh8000, 6'd0);
    send(FUNC_READ, 3'd4, 16'sh0000, 6'd1);
    send(FUNC_READ, 3'd4, 16'sh0000, 6'd2);
    send(FUNC_PUSH, 3'd2, 16'sh0100, 6'd0);
    send(FUNC_READ, 3'd3, 16'sh0000, 6'd0);

    done_items   = 0;
    drained_once = 1'b0;
    while (done_items < RANDOM_ITEMS) begin
      phase = done_items * 4 / RANDOM_ITEMS;
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      if (done_items == 100) long_stall_req = 1'b1;
      if (done_items == 650 && !drained_once) begin
        drained_once = 1'b1;
        wait_drained();
      end

      if ($urandom_range(99) < 10) c = chnum_t'($urandom_range(7));
      else c = chnum_t'($urandom_range(CHANNELS_DEF, 1));
      f = ($urandom_range(99) < 65) ? FUNC_PUSH : FUNC_READ;
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(3))
          0: s = 16'sh8000;
          1: s = 16'sh7fff;
          2: s = 16'sh0000;
          default: s = 16'shffff;
        endcase
      end else begin
        s = sample_t'($urandom);
      end
      send(f, c, s, rdpos_t'($urandom));
      if (c >= 1 && c <= CHANNELS_DEF) done_items++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
